>>> hdl/i2cjs_pkg.sv
// Shared types and constants for the I2C master job sequencer.
// No dependencies.
package i2cjs_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int MAX_BYTES   = 32;

  localparam int QIDX_W = $clog2(QUEUE_DEPTH);
  localparam int OCC_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int SLOT_W = $clog2(MAX_BYTES);
  localparam int CNT_W  = $clog2(MAX_BYTES + 1);
  localparam int DADR_W = QIDX_W + SLOT_W;

  // fixed data widths of the stream beats
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 32;

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_ENQUEUE = 2'd1;
  localparam logic [1:0] OP_EVENT   = 2'd2;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_FULL = 2'd1;
  localparam logic [1:0] ERR_ZERO = 2'd2;

  typedef enum logic [2:0] {
    CMD_NONE     = 3'd0,
    CMD_START    = 3'd1,
    CMD_RESTART  = 3'd2,
    CMD_STOP     = 3'd3,
    CMD_TRANSMIT = 3'd4,
    CMD_RECEIVE  = 3'd5,
    CMD_ACK      = 3'd6,
    CMD_NACK     = 3'd7
  } cmd_t;

  typedef enum logic [3:0] {
    PH_ADDRESSING   = 4'd0,
    PH_ACK_HIGH     = 4'd1,
    PH_ACK_LOW      = 4'd2,
    PH_RESTART      = 4'd3,
    PH_READ_REQUEST = 4'd4,
    PH_READING      = 4'd5,
    PH_WRITING      = 4'd6,
    PH_END          = 4'd7
  } phase_t;

  typedef struct packed {
    logic             rd;
    logic [6:0]       dev;
    logic             wide;
    logic [15:0]      regaddr;
    logic [CNT_W-1:0] count;
  } job_t;

endpackage

>>> hdl/i2c_master_job_sequencer.sv
// I2C master job sequencer: job queue, write-data buffer and bus phase machine.
// Depends on i2cjs_pkg.
//
// Result beat: staged in S_EXEC after the input beat is accepted, and registered while the
// output register is free; a stalled result beat holds the update until it drains.
// Beats do not overlap: in_tready is high only in S_IDLE, so each beat first takes the synchronous read of the
// job memory and write-data memory that it needs before its update.
// Reset: synchronous, active low; queue pointers, phase and handshake cleared.
// Job and write-data memories are not cleared: no clearing pass, usable at once.
module i2c_master_job_sequencer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // tx_slot[4:0] tx_byte[12:5] is_read[13] device_address[20:14]
  // wide_address[21] register_address[37:22] byte_count[43:38]
  // start_done[44] ack_received[45] byte_received[46] rx_byte_in[54:47]
  input  logic [i2cjs_pkg::IN_DATA_W-1:0] in_tdata,
  // opcode[1:0]
  input  logic [1:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // bus_byte[7:0] rx_valid[8] rx_data[16:9] rx_position[21:17]
  // read_done[22] enqueue_error[24:23]
  output logic [i2cjs_pkg::OUT_DATA_W-1:0] out_tdata,
  // bus_command[2:0]
  output logic [2:0]                      out_tuser
);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  // beat staging
  state_t                          state_r;
  logic [i2cjs_pkg::IN_DATA_W-1:0] in_data_r;
  logic [1:0]                      in_op_r;

  // queue and phase state
  logic [i2cjs_pkg::QIDX_W-1:0] head_r, head_nxt;
  logic [i2cjs_pkg::QIDX_W-1:0] tail_r, tail_nxt;
  logic [i2cjs_pkg::OCC_W-1:0]  occ_r, occ_nxt;
  i2cjs_pkg::phase_t            phase_r, phase_nxt;
  logic [i2cjs_pkg::CNT_W-1:0]  bpos_r, bpos_nxt;

  // memories
  i2cjs_pkg::job_t job_mem [i2cjs_pkg::QUEUE_DEPTH];
  logic [7:0]      data_mem [i2cjs_pkg::QUEUE_DEPTH * i2cjs_pkg::MAX_BYTES];
  i2cjs_pkg::job_t job_rd_r;
  logic [7:0]      data_rd_r;

  // output register
  logic                             out_valid_r;
  logic [i2cjs_pkg::OUT_DATA_W-1:0] out_data_r;
  logic [2:0]                       out_cmd_r;

  // unpacked staged fields
  logic [4:0]  f_slot;
  logic [7:0]  f_txb;
  logic        f_rd;
  logic [6:0]  f_dev;
  logic        f_wide;
  logic [15:0] f_reg;
  logic [5:0]  f_cnt;
  logic        f_start, f_ack, f_got;
  logic [7:0]  f_rx;

  assign f_slot  = in_data_r[4:0];
  assign f_txb   = in_data_r[12:5];
  assign f_rd    = in_data_r[13];
  assign f_dev   = in_data_r[20:14];
  assign f_wide  = in_data_r[21];
  assign f_reg   = in_data_r[37:22];
  assign f_cnt   = in_data_r[43:38];
  assign f_start = in_data_r[44];
  assign f_ack   = in_data_r[45];
  assign f_got   = in_data_r[46];
  assign f_rx    = in_data_r[54:47];

  logic in_acc, exec_go;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign exec_go   = (state_r == S_EXEC) && (!out_valid_r || out_tready);

  // write-data read slot: current byte position, clamped to the buffer
  logic [i2cjs_pkg::SLOT_W-1:0] rd_slot;
  assign rd_slot = (int'(bpos_r) < i2cjs_pkg::MAX_BYTES) ?
                   i2cjs_pkg::SLOT_W'(bpos_r) : i2cjs_pkg::SLOT_W'(i2cjs_pkg::MAX_BYTES - 1);

  // update logic
  i2cjs_pkg::cmd_t             cmd;
  logic [7:0]                  bbyte, rxd;
  logic                        rxv, rdone;
  logic [4:0]                  rxp;
  logic [1:0]                  err;
  logic                        job_we, data_we;
  i2cjs_pkg::job_t             job_wd;
  logic [i2cjs_pkg::CNT_W-1:0] bpos_inc;

  assign bpos_inc = bpos_r + 1'b1;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    occ_nxt   = occ_r;
    phase_nxt = phase_r;
    bpos_nxt  = bpos_r;
    cmd       = i2cjs_pkg::CMD_NONE;
    bbyte     = 8'd0;
    rxv       = 1'b0;
    rxd       = 8'd0;
    rxp       = 5'd0;
    rdone     = 1'b0;
    err       = i2cjs_pkg::ERR_NONE;
    job_we    = 1'b0;
    data_we   = 1'b0;
    job_wd.rd      = f_rd;
    job_wd.dev     = f_dev;
    job_wd.wide    = f_wide;
    job_wd.regaddr = f_reg;
    job_wd.count   = (int'(f_cnt) > i2cjs_pkg::MAX_BYTES) ?
                     i2cjs_pkg::CNT_W'(i2cjs_pkg::MAX_BYTES) : i2cjs_pkg::CNT_W'(f_cnt);
    case (in_op_r)
      i2cjs_pkg::OP_LOAD: begin
        data_we = (int'(f_slot) < i2cjs_pkg::MAX_BYTES) &&
                  (int'(occ_r) < i2cjs_pkg::QUEUE_DEPTH);
      end
      i2cjs_pkg::OP_ENQUEUE: begin
        if (f_cnt == 6'd0) begin
          err = i2cjs_pkg::ERR_ZERO;
        end else if (int'(occ_r) >= i2cjs_pkg::QUEUE_DEPTH) begin
          err = i2cjs_pkg::ERR_FULL;
        end else begin
          job_we   = 1'b1;
          head_nxt = (int'(head_r) == i2cjs_pkg::QUEUE_DEPTH - 1) ?
                     '0 : head_r + 1'b1;
          if (occ_r == '0) cmd = i2cjs_pkg::CMD_START;
          occ_nxt = occ_r + 1'b1;
        end
      end
      i2cjs_pkg::OP_EVENT: begin
        case (phase_r)
          i2cjs_pkg::PH_ADDRESSING: begin
            if (f_start) begin
              if (occ_r != '0) begin
                bpos_nxt  = '0;
                cmd       = i2cjs_pkg::CMD_TRANSMIT;
                bbyte     = {job_rd_r.dev, 1'b0};
                phase_nxt = i2cjs_pkg::PH_ACK_HIGH;
              end
            end else if (occ_r != '0) begin
              cmd = i2cjs_pkg::CMD_START;
            end
          end
          i2cjs_pkg::PH_ACK_HIGH: begin
            if (f_ack) begin
              cmd = i2cjs_pkg::CMD_TRANSMIT;
              if (job_rd_r.wide) begin
                bbyte     = job_rd_r.regaddr[15:8];
                phase_nxt = i2cjs_pkg::PH_ACK_LOW;
              end else begin
                bbyte     = job_rd_r.regaddr[7:0];
                phase_nxt = job_rd_r.rd ? i2cjs_pkg::PH_RESTART : i2cjs_pkg::PH_WRITING;
              end
            end
          end
          i2cjs_pkg::PH_ACK_LOW: begin
            if (f_ack) begin
              cmd       = i2cjs_pkg::CMD_TRANSMIT;
              bbyte     = job_rd_r.regaddr[7:0];
              phase_nxt = job_rd_r.rd ? i2cjs_pkg::PH_RESTART : i2cjs_pkg::PH_WRITING;
            end
          end
          i2cjs_pkg::PH_RESTART: begin
            if (f_ack) begin
              cmd       = i2cjs_pkg::CMD_RESTART;
              phase_nxt = i2cjs_pkg::PH_READ_REQUEST;
            end
          end
          i2cjs_pkg::PH_READ_REQUEST: begin
            if (f_start) begin
              cmd       = i2cjs_pkg::CMD_TRANSMIT;
              bbyte     = {job_rd_r.dev, 1'b1};
              phase_nxt = i2cjs_pkg::PH_READING;
            end
          end
          i2cjs_pkg::PH_READING: begin
            if (f_got) begin
              rxv = 1'b1;
              rxd = f_rx;
              rxp = bpos_r[4:0];
              if (bpos_inc >= job_rd_r.count) begin
                bpos_nxt  = '0;
                cmd       = i2cjs_pkg::CMD_NACK;   // last byte of the read
                phase_nxt = i2cjs_pkg::PH_END;
              end else begin
                bpos_nxt = bpos_inc;
                cmd      = i2cjs_pkg::CMD_ACK;
              end
            end else if (f_ack) begin
              cmd = i2cjs_pkg::CMD_RECEIVE;
            end
          end
          i2cjs_pkg::PH_WRITING: begin
            if (f_ack) begin
              cmd      = i2cjs_pkg::CMD_TRANSMIT;
              bbyte    = data_rd_r;
              bpos_nxt = bpos_inc;
              if (bpos_inc >= job_rd_r.count) phase_nxt = i2cjs_pkg::PH_END;
            end
          end
          i2cjs_pkg::PH_END: begin
            cmd   = i2cjs_pkg::CMD_STOP;
            rdone = job_rd_r.rd;
            if (occ_r != '0) begin
              tail_nxt = (int'(tail_r) == i2cjs_pkg::QUEUE_DEPTH - 1) ?
                         '0 : tail_r + 1'b1;
              occ_nxt  = occ_r - 1'b1;
            end
            bpos_nxt  = '0;
            phase_nxt = i2cjs_pkg::PH_ADDRESSING;
          end
          default: begin
            phase_nxt = i2cjs_pkg::PH_ADDRESSING;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // memories: read on acceptance, write back at the end of the update cycle
  always_ff @(posedge clk) begin
    if (in_acc) job_rd_r <= job_mem[tail_r];
    if (exec_go && job_we) job_mem[head_r] <= job_wd;
  end

  always_ff @(posedge clk) begin
    if (in_acc) data_rd_r <= data_mem[{tail_r, rd_slot}];
    if (exec_go && data_we) data_mem[{head_r, i2cjs_pkg::SLOT_W'(f_slot)}] <= f_txb;
  end

  // payload staging
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_data_r <= in_tdata;
      in_op_r   <= in_tuser;
    end
  end

  // control state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
      occ_r       <= '0;
      phase_r     <= i2cjs_pkg::PH_ADDRESSING;
      bpos_r      <= '0;
    end else begin
      // a new result beat takes the slot; otherwise a taken beat empties it
      if (exec_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) state_r <= S_EXEC;
        end
        S_EXEC: begin
          if (exec_go) begin
            state_r     <= S_IDLE;
            head_r      <= head_nxt;
            tail_r      <= tail_nxt;
            occ_r       <= occ_nxt;
            phase_r     <= phase_nxt;
            bpos_r      <= bpos_nxt;
            out_data_r  <= {7'd0, err, rdone, rxp, rxd, rxv, bbyte};
            out_cmd_r   <= cmd;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_cmd_r;

  // queue never overfills
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(occ_r) <= i2cjs_pkg::QUEUE_DEPTH)
    else $error("queue occupancy above depth");

  // a job in flight always has its queue entry
  a_phase_has_job: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != i2cjs_pkg::PH_ADDRESSING) |-> (occ_r != '0))
    else $error("active phase with empty queue");

  // pointers meet only when the queue is empty or full
  a_ptr_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r == tail_r) |->
      (occ_r == '0 || int'(occ_r) == i2cjs_pkg::QUEUE_DEPTH))
    else $error("queue pointers disagree with occupancy");

  // occupancy, phase and head pointer change only on an update cycle
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !exec_go |=> ($stable(occ_r) && $stable(phase_r) && $stable(head_r)))
    else $error("queue state changed outside an update");

endmodule
